/* hw/rtl/ppaom_pkg.sv */
package ppaom_pkg;

  // Operation codes carried in the op field
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DROP   = 2'd1,
    OP_NEXT   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DONE
  } state_t;

  // Fixed field widths of the channels
  localparam int OP_BITS     = 2;
  localparam int PORT_BITS   = 4;
  localparam int QID_IO_BITS = 8;
  localparam int MAXLEN_BITS = 16;
  localparam int COUNT_BITS  = 7;
  localparam int STATUS_BITS = 2;

endpackage

/* hw/rtl/ppaom_cmd_if.sv */
interface ppaom_cmd_if
  import ppaom_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [OP_BITS-1:0]     op;
  logic [PORT_BITS-1:0]   port;
  logic                   direction;
  logic [QID_IO_BITS-1:0] queue_id;
  logic [MAXLEN_BITS-1:0] max_length;

  modport source (output valid, op, port, direction, queue_id, max_length, input ready);
  modport sink   (input valid, op, port, direction, queue_id, max_length, output ready);
endinterface

/* hw/rtl/ppaom_rsp_if.sv */
interface ppaom_rsp_if
  import ppaom_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [QID_IO_BITS-1:0] served_queue;
  logic                   served_valid;
  logic                   drop_flag;
  logic [COUNT_BITS-1:0]  entry_count;
  logic [STATUS_BITS-1:0] status;

  modport source (output valid, served_queue, served_valid, drop_flag, entry_count, status,
                  input ready);
  modport sink   (input valid, served_queue, served_valid, drop_flag, entry_count, status,
                  output ready);
endinterface

/* hw/rtl/ppaom_ram.sv */
module ppaom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/per_port_arrival_order_monitor.sv */
// Per-port arrival order monitor.
// Every port keeps two FIFO lists of queue numbers (input and output
// direction), in arrival order. The cmd channel carries one word per
// operation: insert appends queue_id, drop removes the newest entry, next
// pops the oldest entry and returns it, drop query compares the list's
// entry count with max_length. The rsp channel returns exactly one word
// per cmd word, in order.
// The head/count memory is read at accept, the lookup state updates it
// and reads the store memory (next op), and the done state loads the rsp
// register. The block works on one word at a time: cmd ready is high
// only in the idle state.
// When the receiver stalls, the finished word waits in the rsp output
// register; the block still takes one more cmd word and holds its result
// until the output register frees, while cmd ready stays low.
// Reset: all lists read as empty right after reset (per-list valid bits
// cleared at once); the queue number store needs no clearing pass.
module per_port_arrival_order_monitor
  import ppaom_pkg::*;
#(
  parameter int PORTS         = 16,
  parameter int LIST_DEPTH    = 64,
  parameter int QUEUE_ID_BITS = 8
) (
  input logic         clk,
  input logic         rst,
  ppaom_cmd_if.sink   cmd,
  ppaom_rsp_if.source rsp
);

  // only ports the 4-bit port field can name get a list
  localparam int PORTS_USED = (PORTS < (1 << PORT_BITS)) ? PORTS : (1 << PORT_BITS);
  localparam int LISTS      = 2 * PORTS_USED;
  localparam int LW         = $clog2(LISTS);
  localparam int IX         = (LW > PORT_BITS + 1) ? LW : PORT_BITS + 1;
  localparam int PW         = $clog2(LIST_DEPTH);
  localparam int CW         = $clog2(LIST_DEPTH + 1);
  localparam int SW         = CW + 1;
  localparam int CX         = (CW > COUNT_BITS) ? CW : COUNT_BITS;
  localparam int MX         = (CW > MAXLEN_BITS) ? CW : MAXLEN_BITS;
  localparam int QX         = (QUEUE_ID_BITS > QID_IO_BITS) ? QUEUE_ID_BITS : QID_IO_BITS;
  localparam int SDEPTH     = LISTS * LIST_DEPTH;
  localparam int AW         = $clog2(SDEPTH);

  state_t state, state_next;

  // captured cmd word
  op_t                      cur_op;
  logic [PORT_BITS-1:0]     cur_port;
  logic [LW-1:0]            cur_idx;
  logic [QUEUE_ID_BITS-1:0] cur_qid;
  logic [MAXLEN_BITS-1:0]   cur_maxlen;

  logic [LISTS-1:0] list_valid;

  // pointer memory
  logic                ptr_re, ptr_we;
  logic [LW-1:0]       ptr_raddr;
  logic [PW+CW-1:0]    ptr_rdata, ptr_wdata;

  // store memory
  logic                     st_we, st_re;
  logic [AW-1:0]            st_addr;
  logic [QUEUE_ID_BITS-1:0] st_rdata;

  // lookup stage signals
  logic [PW-1:0]  h_rd, h_new, tail, h_inc;
  logic [CW-1:0]  c_rd, c_new;
  logic [SW-1:0]  tail_sum;
  logic [PW-1:0]  st_pos;
  logic           port_ok;
  logic           lk_served, lk_drop;
  status_t        lk_status;
  logic [CX-1:0]  cnt_ext;
  logic [IX-1:0]  cmd_idx_ext;
  logic [QX-1:0]  qid_in_ext, qid_out_ext;

  // staged result
  logic                   res_served, res_drop;
  logic [COUNT_BITS-1:0]  res_count;
  status_t                res_status;

  logic out_free;

  assign cmd_idx_ext = IX'({cmd.port, cmd.direction});
  assign ptr_raddr   = cmd_idx_ext[LW-1:0];
  assign qid_in_ext  = QX'(cmd.queue_id);
  assign out_free    = !rsp.valid || rsp.ready;

  // capture cmd word at accept
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cur_op     <= op_t'(cmd.op);
      cur_port   <= cmd.port;
      cur_idx    <= ptr_raddr;
      cur_qid    <= qid_in_ext[QUEUE_ID_BITS-1:0];
      cur_maxlen <= cmd.max_length;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (cmd.valid) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer outputs
  always_comb begin
    cmd.ready = (state == ST_IDLE);
    ptr_re    = (state == ST_IDLE) && cmd.valid;
    ptr_we    = (state == ST_LOOKUP) && port_ok;
  end

  // unwritten list reads as empty
  assign h_rd = list_valid[cur_idx] ? ptr_rdata[PW+CW-1:CW] : '0;
  assign c_rd = list_valid[cur_idx] ? ptr_rdata[CW-1:0]     : '0;

  assign port_ok = (32'(cur_port) < PORTS_USED);

  // tail position and head advance, both wrap at LIST_DEPTH
  assign tail_sum = SW'(h_rd) + SW'(c_rd);
  assign tail     = (tail_sum >= SW'(LIST_DEPTH)) ? PW'(tail_sum - SW'(LIST_DEPTH))
                                                  : tail_sum[PW-1:0];
  assign h_inc    = (h_rd == PW'(LIST_DEPTH - 1)) ? '0 : h_rd + 1'b1;

  // operation decode on the looked-up list
  always_comb begin
    h_new     = h_rd;
    c_new     = c_rd;
    lk_served = 1'b0;
    lk_drop   = 1'b0;
    lk_status = STAT_OK;
    st_pos    = tail;
    st_we     = 1'b0;
    st_re     = 1'b0;
    if (!port_ok) begin
      c_new     = '0;
      lk_status = (cur_op == OP_NEXT) ? STAT_EMPTY : STAT_OK;
    end else begin
      case (cur_op)
        OP_INSERT: begin
          if (c_rd == CW'(LIST_DEPTH)) begin
            lk_status = STAT_FULL;
          end else begin
            st_we = (state == ST_LOOKUP);
            c_new = c_rd + 1'b1;
          end
        end
        OP_DROP: begin
          if (c_rd == '0) begin
            lk_status = STAT_EMPTY;
          end else begin
            c_new = c_rd - 1'b1;
          end
        end
        OP_NEXT: begin
          st_pos = h_rd;
          if (c_rd == '0) begin
            lk_status = STAT_EMPTY;
          end else begin
            st_re     = (state == ST_LOOKUP);
            lk_served = 1'b1;
            h_new     = h_inc;
            c_new     = c_rd - 1'b1;
          end
        end
        default: begin
          lk_drop = (MX'(c_rd) >= MX'(cur_maxlen));
        end
      endcase
    end
  end

  assign ptr_wdata = {h_new, c_new};
  assign st_addr   = AW'(cur_idx) * AW'(LIST_DEPTH) + AW'(st_pos);
  assign cnt_ext   = CX'(c_new);

  // per-list valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      list_valid <= '0;
    end else if (ptr_we) begin
      list_valid[cur_idx] <= 1'b1;
    end
  end

  // stage result of lookup
  always_ff @(posedge clk) begin
    if (state == ST_LOOKUP) begin
      res_served <= lk_served;
      res_drop   <= lk_drop;
      res_count  <= cnt_ext[COUNT_BITS-1:0];
      res_status <= lk_status;
    end
  end

  assign qid_out_ext = QX'(st_rdata);

  // rsp output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      rsp.served_queue <= res_served ? qid_out_ext[QID_IO_BITS-1:0] : '0;
      rsp.served_valid <= res_served;
      rsp.drop_flag    <= res_drop;
      rsp.entry_count  <= res_count;
      rsp.status       <= res_status;
    end
  end

  // head and count per list
  ppaom_ram #(
    .WIDTH(PW + CW),
    .DEPTH(LISTS)
  ) u_ptr_ram (
    .clk  (clk),
    .we   (ptr_we),
    .waddr(cur_idx),
    .wdata(ptr_wdata),
    .re   (ptr_re),
    .raddr(ptr_raddr),
    .rdata(ptr_rdata)
  );

  // queue numbers of all lists
  ppaom_ram #(
    .WIDTH(QUEUE_ID_BITS),
    .DEPTH(SDEPTH)
  ) u_store_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr(st_addr),
    .wdata(cur_qid),
    .re   (st_re),
    .raddr(st_addr),
    .rdata(st_rdata)
  );

endmodule

/* hw/rtl/ppaom_checker.sv */
module ppaom_checker
  import ppaom_pkg::*;
#(
  parameter int LIST_DEPTH = 64
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   cmd_valid,
  input logic                   cmd_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic [QID_IO_BITS-1:0] served_queue,
  input logic                   served_valid,
  input logic                   drop_flag,
  input logic [COUNT_BITS-1:0]  entry_count,
  input logic [STATUS_BITS-1:0] status
);

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int CX = (CW > COUNT_BITS) ? CW : COUNT_BITS;

  // a popped word leaves the list below full, with status ok
  a_served_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && served_valid) |->
      (status == STAT_OK && CX'(entry_count) < CX'(LIST_DEPTH)))
    else $error("served word with bad status or count");

  // drop flag and served queue only where their op allows
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!(drop_flag && served_valid) && (served_valid || served_queue == '0)
                   && (!drop_flag || status == STAT_OK)))
    else $error("drop flag or served queue on wrong result");

  // one word at a time: ready drops after each accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("cmd ready held after accept");

  // stalled rsp word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(served_queue) && $stable(served_valid) && $stable(drop_flag)
       && $stable(entry_count) && $stable(status)))
    else $error("rsp word changed while stalled");

endmodule

bind per_port_arrival_order_monitor ppaom_checker #(
  .LIST_DEPTH(LIST_DEPTH)
) u_ppaom_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .served_queue(rsp.served_queue),
  .served_valid(rsp.served_valid),
  .drop_flag   (rsp.drop_flag),
  .entry_count (rsp.entry_count),
  .status      (rsp.status)
);
